// ===== rtl/core/prq_pkg.sv =====
// process ready queue package: record, request and cell control types, operation, status and mode codes
// no dependencies; used by every file of the queue
package prq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OCC_W       = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_STF  = 2'd1;
  localparam logic [1:0] MODE_RR   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] proc_id;
    logic [31:0] service_time;
    logic [31:0] arrival_time;
    logic [15:0] quantum;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      out_id;
    logic [31:0]      out_service_time;
    logic [31:0]      out_arrival_time;
    logic [15:0]      out_quantum;
    logic [OCC_W-1:0] occupancy;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] proc_id;
    logic [31:0] service_time;
    logic [31:0] arrival_time;
    logic [15:0] quantum;
  } rec_t;

  typedef struct packed {
    logic en;
    logic ins;
    logic pop;
    logic sorted;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/prq_cell.sv =====
// one queue slot: holds a record, finds the insert or removal point along the chain
// and shifts towards its neighbours; depends on prq_pkg
module prq_cell import prq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_rec_i,
  input  logic       valid_i,
  input  rec_t       prev_rec_i,
  input  rec_t       next_rec_i,
  input  logic       hit_before_i,
  input  rec_t       taken_i,
  output rec_t       rec_o,
  output logic       hit_before_o,
  output rec_t       taken_o
);

  rec_t rec_q, rec_d;
  logic hit, first;

  always_comb begin
    if (ctrl_i.ins) begin
      hit = !valid_i || (ctrl_i.sorted && (rec_q.service_time >= new_rec_i.service_time));
    end else begin
      hit = valid_i && (ctrl_i.pop || (rec_q.proc_id == new_rec_i.proc_id));
    end
  end

  assign first        = hit && !hit_before_i;
  assign hit_before_o = hit_before_i || hit;
  assign taken_o      = rec_t'(taken_i | ((first && !ctrl_i.ins) ? rec_q : rec_t'('0)));
  assign rec_o        = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.en) begin
      if (ctrl_i.ins) begin
        if (first) begin
          rec_d = new_rec_i;
        end else if (hit_before_i) begin
          rec_d = prev_rec_i;
        end
      end else if (hit_before_o) begin
        rec_d = next_rec_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// ===== rtl/core/process_ready_queue.sv =====
// process ready queue top level: chain of slot cells, entry count, order mode register
// and result register; depends on prq_pkg and prq_cell
//
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, in_req_i  | request into the queue
//  out     | out_valid_o, out_stall_i, out_rsp_o | one result per request
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | order mode write
//
// one request per cycle while the input is not stalled; all slots compare and shift together in the cycle of acceptance
// the result appears in the result register on the next cycle
// the position search ripples through the slot chain, one or gate per slot
// reset empties the queue and sets first-come order; slot contents are not cleared
// a stalled result holds and stalls the input until it is taken
module process_ready_queue import prq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_req_t    in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_rsp_t   out_rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  logic [1:0]       mode_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_rsp_t         out_rsp_q, out_rsp_d;

  logic       accept, found, change;
  logic [1:0] status;
  cell_ctrl_t ctrl;
  rec_t       new_rec;

  rec_t recs     [QUEUE_DEPTH];
  rec_t prev_recs[QUEUE_DEPTH];
  rec_t next_recs[QUEUE_DEPTH];
  logic hit_chain  [QUEUE_DEPTH+1];
  rec_t taken_chain[QUEUE_DEPTH+1];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign new_rec = '{proc_id:      in_req_i.proc_id,
                     service_time: in_req_i.service_time,
                     arrival_time: in_req_i.arrival_time,
                     quantum:      in_req_i.quantum};

  always_comb begin
    status = ST_OK;
    change = 1'b0;
    count_d = count_q;
    unique case (in_req_i.op)
      OP_INSERT: begin
        if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          change  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP, OP_REMOVE: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOTFOUND;
        end else begin
          change  = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!accept || !change) begin
      count_d = count_q;
    end
  end

  assign ctrl.en     = accept && change;
  assign ctrl.ins    = (in_req_i.op == OP_INSERT);
  assign ctrl.pop    = (in_req_i.op == OP_POP);
  assign ctrl.sorted = (mode_q == MODE_STF);

  assign hit_chain[0]   = 1'b0;
  assign taken_chain[0] = '0;
  assign found          = hit_chain[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_recs[i] = '0;
    end else begin : g_mid
      assign prev_recs[i] = recs[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_recs[i] = '0;
    end else begin : g_body
      assign next_recs[i] = recs[i+1];
    end

    prq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_rec_i    (new_rec),
      .valid_i      (count_q > CNT_W'(i)),
      .prev_rec_i   (prev_recs[i]),
      .next_rec_i   (next_recs[i]),
      .hit_before_i (hit_chain[i]),
      .taken_i      (taken_chain[i]),
      .rec_o        (recs[i]),
      .hit_before_o (hit_chain[i+1]),
      .taken_o      (taken_chain[i+1])
    );
  end

  always_comb begin
    out_rsp_d = '0;
    out_rsp_d.status    = status;
    out_rsp_d.occupancy = OCC_W'(count_d);
    if (change && !ctrl.ins) begin
      out_rsp_d.out_id           = taken_chain[QUEUE_DEPTH].proc_id;
      out_rsp_d.out_service_time = taken_chain[QUEUE_DEPTH].service_time;
      out_rsp_d.out_arrival_time = taken_chain[QUEUE_DEPTH].arrival_time;
      out_rsp_d.out_quantum      = taken_chain[QUEUE_DEPTH].quantum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FCFS;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      count_q     <= count_d;
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== rtl/core/prq_checker.sv =====
// port-level checks for the process ready queue, bound to the top level
// depends on prq_pkg and process_ready_queue
module prq_checker import prq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_rsp_t   out_rsp_o
);

  // stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // every accepted request yields a result next cycle
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("request without result");

  // failed operations carry no record
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |->
      (out_rsp_o.out_id == '0) && (out_rsp_o.out_service_time == '0) &&
      (out_rsp_o.out_arrival_time == '0) && (out_rsp_o.out_quantum == '0))
    else $error("record on failed operation");

  // full only reported at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_FULL) |->
      out_rsp_o.occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full below capacity");

  // empty only reported with no entries
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_EMPTY) |-> out_rsp_o.occupancy == '0)
    else $error("empty with entries");

endmodule

bind process_ready_queue prq_checker u_prq_checker (.*);
